@@ rtl/gbn_pkg.sv @@
// Shared types and constants for the go-back-n sender window block.
// No dependencies; imported by gbn_alu and go_back_n_sender_window.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int unsigned SEGMENT_BYTES = 512;
  localparam int unsigned SEG_SHIFT     = $clog2(SEGMENT_BYTES);

  // width of the sequencer's signed working values (-1 .. ~270)
  localparam int unsigned VAL_W = 10;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 40;

  // input func codes
  localparam logic [1:0] FN_START   = 2'd0;
  localparam logic [1:0] FN_ACK     = 2'd1;
  localparam logic [1:0] FN_TIMEOUT = 2'd2;
  localparam logic [1:0] FN_NONE    = 2'd3;

  // result kinds
  localparam logic [2:0] K_DATA   = 3'd0;
  localparam logic [2:0] K_ERRMSG = 3'd1;
  localparam logic [2:0] K_DONE   = 3'd2;
  localparam logic [2:0] K_FAIL   = 3'd3;
  localparam logic [2:0] K_REJECT = 3'd4;

  // message checks
  localparam logic [10:0] REQ_LEN_MIN = 11'd4;
  localparam logic [10:0] REQ_LEN_MAX = 11'd22;
  localparam logic [7:0]  TYPE_RRQ    = 8'd1;
  localparam logic [10:0] ACK_LEN     = 11'd2;
  localparam logic [7:0]  TYPE_ACK    = 8'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_ACK_SEQ_LIMIT = 2'd2;

  localparam logic [3:0] RST_TIMEOUT_LIMIT = 4'd5;
  localparam logic [3:0] RST_WINDOW_LIMIT  = 4'd9;
  localparam logic [7:0] RST_ACK_SEQ_LIMIT = 8'd50;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic lt;   // a < b (subtract)
    logic eq;   // a == b (subtract)
  } alu_flags_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLAMP,
    ST_ACK,
    ST_TOP,
    ST_RANGE,
    ST_END,
    ST_FIRST,
    ST_INC,
    ST_CHK,
    ST_SEND,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

@@ rtl/gbn_alu.sv @@
// Shared add/subtract-compare unit for the window sequencer.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_alu (
  input  wire gbn_pkg::alu_op_t          op,
  input  wire logic signed [gbn_pkg::VAL_W-1:0] a,
  input  wire logic signed [gbn_pkg::VAL_W-1:0] b,
  output logic signed [gbn_pkg::VAL_W-1:0]      res,
  output gbn_pkg::alu_flags_t            flags
);
  import gbn_pkg::*;

  logic signed [VAL_W:0] a_x;
  logic signed [VAL_W:0] b_x;
  logic signed [VAL_W:0] sum;
  logic                  sub;

  always_comb begin
    sub   = (op == ALU_SUB);
    a_x   = {a[VAL_W-1], a};
    b_x   = {b[VAL_W-1], b};
    sum   = a_x + (sub ? ~b_x : b_x) + {{VAL_W{1'b0}}, sub};
    res   = sum[VAL_W-1:0];
    flags.lt = sub & sum[VAL_W];
    flags.eq = sub & (sum == '0);
  end

endmodule

`default_nettype wire

@@ rtl/go_back_n_sender_window.sv @@
// Go-Back-N sender window control: request/ack/timeout items in, segment
// descriptors and status results out. Depends on gbn_pkg and gbn_alu.
//
// One item is handled at a time; s_tready is high only while idle, and the
// item is accepted there. A decode step follows; a request adds a clamp step
// and an ack a compare step. A window pass then runs its setup steps on the
// shared adder (top, range, an end check when the window reaches the last
// segment, first, increment), followed by a check and a send step per emitted
// segment. A single status result (done, failed, rejected, error) is offered
// from a final step after the step that decides it. Send and final steps wait
// while m_tready is low. Results are offered on m_tvalid with tlast marking
// the last result of the item; items with no result just return to idle.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item in
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // msg_len[10:0], msg_code[18:11], msg_arg[26:19], file_found[27],
  // fsize[43:28]
  input  wire logic [gbn_pkg::S_TDATA_W-1:0]   s_tdata,
  // func[1:0]
  input  wire logic [1:0]                      s_tuser,
  // result out
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // seq_no[6:0], seg_offset[22:7], seg_len[32:23]
  output logic [gbn_pkg::M_TDATA_W-1:0]        m_tdata,
  // kind[2:0]
  output logic [2:0]                           m_tuser,
  output logic                                 m_tlast,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_addr,
  input  wire logic [7:0]                      cfg_wdata
);
  import gbn_pkg::*;

  state_t state, state_next;

  // config
  logic [3:0] timeout_limit;
  logic [3:0] window_limit;
  logic [7:0] ack_seq_limit;

  // latched item
  logic [1:0]  func;
  logic [10:0] msg_len;
  logic [7:0]  msg_code;
  logic [7:0]  msg_arg;
  logic        file_found;
  logic [15:0] fsize;

  // window state
  logic              busy, busy_next;
  logic [3:0]        window_size, window_size_next;
  logic [6:0]        top_seq, top_seq_next;
  logic [8:0]        final_len, final_len_next;
  logic signed [8:0] last_sent, last_sent_next;
  logic signed [8:0] last_acked, last_acked_next;
  logic              final_window, final_window_next;
  logic [3:0]        timeout_count, timeout_count_next;

  // sequencer working regs
  logic signed [VAL_W-1:0] top_r, top_r_next;
  logic signed [VAL_W-1:0] cur, cur_next;
  logic                    is_last, is_last_next;
  logic [9:0]              seg_len_r, seg_len_r_next;
  logic [2:0]              fin_kind, fin_kind_next;

  // shared unit
  alu_op_t                 alu_op;
  logic signed [VAL_W-1:0] alu_a;
  logic signed [VAL_W-1:0] alu_b;
  logic signed [VAL_W-1:0] alu_res;
  alu_flags_t              alu_flags;

  gbn_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  logic [3:0]              tc_inc;
  logic                    req_bad;
  logic                    ack_bad;
  logic signed [VAL_W-1:0] acked_x;
  logic signed [VAL_W-1:0] sent_x;
  logic signed [VAL_W-1:0] top_seq_x;
  logic [15:0]             seg_offset;

  assign acked_x   = {last_acked[8], last_acked};
  assign sent_x    = {last_sent[8], last_sent};
  assign top_seq_x = {3'b000, top_seq};
  assign tc_inc    = timeout_count + 4'd1;

  assign req_bad = (msg_len < REQ_LEN_MIN) || (msg_len > REQ_LEN_MAX) ||
                   (msg_code != TYPE_RRQ) || (msg_arg == 8'd0) ||
                   (msg_arg > {4'b0000, window_limit});
  assign ack_bad = (msg_len != ACK_LEN) || (msg_code != TYPE_ACK) ||
                   (msg_arg > ack_seq_limit);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= RST_TIMEOUT_LIMIT;
      window_limit  <= RST_WINDOW_LIMIT;
      ack_seq_limit <= RST_ACK_SEQ_LIMIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_wdata[3:0];
        CFG_WINDOW_LIMIT:  window_limit  <= cfg_wdata[3:0];
        CFG_ACK_SEQ_LIMIT: ack_seq_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func       <= s_tuser;
      msg_len    <= s_tdata[10:0];
      msg_code   <= s_tdata[18:11];
      msg_arg    <= s_tdata[26:19];
      file_found <= s_tdata[27];
      fsize      <= s_tdata[43:28];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= 1'b0;
      window_size   <= '0;
      top_seq       <= '0;
      final_len     <= '0;
      last_sent     <= '1;
      last_acked    <= '1;
      final_window  <= 1'b0;
      timeout_count <= '0;
    end else begin
      state         <= state_next;
      busy          <= busy_next;
      window_size   <= window_size_next;
      top_seq       <= top_seq_next;
      final_len     <= final_len_next;
      last_sent     <= last_sent_next;
      last_acked    <= last_acked_next;
      final_window  <= final_window_next;
      timeout_count <= timeout_count_next;
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_r_next;
    cur       <= cur_next;
    is_last   <= is_last_next;
    seg_len_r <= seg_len_r_next;
    fin_kind  <= fin_kind_next;
  end

  always_comb begin
    state_next         = state;
    busy_next          = busy;
    window_size_next   = window_size;
    top_seq_next       = top_seq;
    final_len_next     = final_len;
    last_sent_next     = last_sent;
    last_acked_next    = last_acked;
    final_window_next  = final_window;
    timeout_count_next = timeout_count;
    top_r_next         = top_r;
    cur_next           = cur;
    is_last_next       = is_last;
    seg_len_r_next     = seg_len_r;
    fin_kind_next      = fin_kind;
    alu_op             = ALU_SUB;
    alu_a              = cur;
    alu_b              = top_r;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (func == FN_NONE) begin
          state_next = ST_IDLE;
        end else if (!busy) begin
          if (func == FN_TIMEOUT) begin
            state_next = ST_IDLE;
          end else if (req_bad) begin
            fin_kind_next = K_REJECT;
            state_next    = ST_FIN;
          end else if (!file_found) begin
            fin_kind_next = K_ERRMSG;
            state_next    = ST_FIN;
          end else begin
            busy_next      = 1'b1;
            top_seq_next   = fsize[15:SEG_SHIFT];
            final_len_next = fsize[SEG_SHIFT-1:0];
            state_next     = ST_CLAMP;
          end
        end else if (func == FN_TIMEOUT) begin
          if (tc_inc >= timeout_limit) begin
            fin_kind_next = K_FAIL;
            state_next    = ST_FIN;
          end else begin
            timeout_count_next = tc_inc;
            last_sent_next     = last_acked;
            state_next         = ST_TOP;
          end
        end else if (ack_bad) begin
          fin_kind_next = K_FAIL;
          state_next    = ST_FIN;
        end else begin
          state_next = ST_ACK;
        end
      end

      ST_CLAMP: begin
        alu_a = top_seq_x;
        alu_b = {2'b00, msg_arg};
        window_size_next = alu_flags.lt ? (top_seq[3:0] + 4'd1) : msg_arg[3:0];
        state_next = ST_TOP;
      end

      ST_ACK: begin
        alu_a = {2'b00, msg_arg};
        alu_b = acked_x;
        if (alu_flags.lt) begin
          state_next = ST_IDLE;
        end else begin
          timeout_count_next = '0;
          if (final_window) begin
            if (msg_arg == {1'b0, top_seq}) begin
              fin_kind_next = K_DONE;
              state_next    = ST_FIN;
            end else begin
              last_acked_next = {1'b0, msg_arg};
              state_next      = ST_IDLE;
            end
          end else begin
            last_acked_next = {1'b0, msg_arg};
            state_next      = ST_TOP;
          end
        end
      end

      ST_TOP: begin
        alu_op     = ALU_ADD;
        alu_a      = acked_x;
        alu_b      = {6'b000000, window_size};
        top_r_next = alu_res;
        state_next = ST_RANGE;
      end

      ST_RANGE: begin
        alu_a = top_r;
        alu_b = top_seq_x;
        if (!alu_flags.lt) begin
          top_r_next = top_seq_x;
          state_next = ST_END;
        end else begin
          state_next = ST_FIRST;
        end
      end

      ST_END: begin
        alu_a = acked_x;
        alu_b = top_seq_x;
        if (!alu_flags.lt) begin
          fin_kind_next = K_DONE;
          state_next    = ST_FIN;
        end else begin
          final_window_next = 1'b1;
          state_next        = ST_FIRST;
        end
      end

      ST_FIRST: begin
        alu_a      = sent_x;
        alu_b      = acked_x;
        cur_next   = alu_flags.lt ? acked_x : sent_x;
        state_next = ST_INC;
      end

      ST_INC: begin
        alu_op     = ALU_ADD;
        alu_a      = cur;
        alu_b      = VAL_W'(1);
        cur_next   = alu_res;
        state_next = ST_CHK;
      end

      ST_CHK: begin
        alu_a = top_r;
        alu_b = cur;
        if (alu_flags.lt) begin
          state_next = ST_IDLE;
        end else begin
          is_last_next   = alu_flags.eq;
          seg_len_r_next = (final_window && (cur == top_seq_x)) ?
                           {1'b0, final_len} : 10'(SEGMENT_BYTES);
          state_next     = ST_SEND;
        end
      end

      ST_SEND: begin
        alu_op = ALU_ADD;
        alu_a  = cur;
        alu_b  = VAL_W'(1);
        if (m_tready) begin
          last_sent_next = cur[8:0];
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            cur_next   = alu_res;
            state_next = ST_CHK;
          end
        end
      end

      ST_FIN: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // done and failed return the window state to idle
    if (state != ST_FIN && state_next == ST_FIN &&
        (fin_kind_next == K_DONE || fin_kind_next == K_FAIL)) begin
      busy_next          = 1'b0;
      window_size_next   = '0;
      top_seq_next       = '0;
      final_len_next     = '0;
      last_sent_next     = '1;
      last_acked_next    = '1;
      final_window_next  = 1'b0;
      timeout_count_next = '0;
    end
  end

  assign seg_offset = 16'(cur[6:0]) << SEG_SHIFT;

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_SEND) || (state == ST_FIN);
    if (state == ST_SEND) begin
      m_tuser = K_DATA;
      m_tlast = is_last;
      m_tdata = {7'b0000000, seg_len_r, seg_offset, cur[6:0]};
    end else begin
      m_tuser = fin_kind;
      m_tlast = 1'b1;
      m_tdata = '0;
    end
  end

endmodule

`default_nettype wire
